@@ rtl/deque_with_search_top_assert.svh @@
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dqs_pkg.sv @@
// Types and constants of the deque with search.
`timescale 1ns / 1ps
package dqs_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;

  // Value reported for front and back of an empty deque.
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  // Match bits checked per scan cycle.
  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = $clog2(LANES);

  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_e;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic load;       // take the request value
    logic shift_fwd;  // take the neighbor toward the front
    logic shift_bwd;  // take the neighbor toward the back
    logic cmp;        // latch the search match bit
    logic active;     // cell holds a stored element
  } cell_ctl_t;

endpackage

@@ rtl/dqs_if.sv @@
// Request and response channel interfaces of the deque.
`timescale 1ns / 1ps
interface dqs_req_if;
  logic              valid;
  logic              ready;
  logic        [2:0] req_type;
  logic signed [31:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface dqs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic         [4:0] element_count;
  logic               is_empty;
  logic               found;
  logic         [3:0] found_position;
  logic         [1:0] status;

  modport source (output valid, output front_value, output back_value,
                  output element_count, output is_empty, output found,
                  output found_position, output status, input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input element_count, input is_empty, input found,
                  input found_position, input status, output ready);
endinterface

@@ rtl/dqs_cell.sv @@
// One storage cell of the deque chain with its search comparator.
`timescale 1ns / 1ps
module dqs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqs_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0] item_i,
  input  logic signed [31:0] prev_i,
  input  logic signed [31:0] next_i,
  output logic signed [31:0] value_o,
  output logic               hit_o
);

  logic signed [31:0] value_q, value_d;
  logic               hit_q, hit_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.load) begin
      value_d = item_i;
    end else if (ctl_i.shift_fwd) begin
      value_d = prev_i;
    end else if (ctl_i.shift_bwd) begin
      value_d = next_i;
    end
  end

  assign hit_d = ctl_i.cmp ? (ctl_i.active && (value_q == item_i)) : hit_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

@@ rtl/dqs_scan.sv @@
// First-match scanner over the cell match bits, one lane group per cycle.
`timescale 1ns / 1ps
module dqs_scan #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DEPTH-1:0]         hit_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic [$clog2(DEPTH)-1:0] pos_o
);

  localparam int unsigned NGRP  = (DEPTH + dqs_pkg::LANES - 1) / dqs_pkg::LANES;
  localparam int unsigned GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam int unsigned PAD_W = NGRP * dqs_pkg::LANES;

  logic                           busy_q, busy_d;
  logic [GRP_W-1:0]               grp_q, grp_d;
  logic                           found_q, found_d;
  logic [POS_W-1:0]               pos_q, pos_d;
  logic [PAD_W-1:0]               hit_pad;
  logic [dqs_pkg::LANES-1:0]      lane_hit;
  logic [dqs_pkg::LANE_W-1:0]     lane_sel;
  logic                           any_hit;
  logic                           last_grp;

  assign hit_pad  = PAD_W'(hit_i);
  assign lane_hit = hit_pad[grp_q*dqs_pkg::LANES +: dqs_pkg::LANES];
  assign any_hit  = |lane_hit;
  assign last_grp = (grp_q == GRP_W'(NGRP - 1));

  // Lowest set lane wins.
  always_comb begin
    lane_sel = '0;
    for (int k = dqs_pkg::LANES - 1; k >= 0; k--) begin
      if (lane_hit[k]) begin
        lane_sel = dqs_pkg::LANE_W'(k);
      end
    end
  end

  assign done_o = busy_q && (any_hit || last_grp);

  always_comb begin
    busy_d  = busy_q;
    grp_d   = grp_q;
    found_d = found_q;
    pos_d   = pos_q;
    if (start_i) begin
      busy_d = 1'b1;
      grp_d  = '0;
    end else if (done_o) begin
      busy_d  = 1'b0;
      found_d = any_hit;
      pos_d   = any_hit ? POS_W'({grp_q, lane_sel}) : '0;
    end else if (busy_q) begin
      grp_d = grp_q + GRP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      grp_q   <= '0;
      found_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      grp_q   <= grp_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign found_o = found_q;
  assign pos_o   = pos_q;

endmodule

@@ rtl/deque_with_search_top.sv @@
// Top level of the bounded double-ended queue with search.
`timescale 1ns / 1ps
// Bounded deque of up to DEPTH signed 32-bit values, held in a chain of cells
// with cell 0 at the front. A request is taken in the cycle it is accepted:
// push front shifts every cell one place toward the back, pop front shifts one
// place toward the front, push back writes the cell at the current count and
// pop back only lowers the count. Each response reports front and back values
// (0x7FFFFFFF when empty), the count, the empty flag, the search result and a
// status code (push on a full deque and pop on an empty one leave the state
// unchanged). A push or pop is applied on acceptance; S_REPORT then loads the
// response register, waiting while an older one is unread. A search latches
// match bits on acceptance; the scanner walks the 8-cell groups in S_SCAN up
// to the one holding the first match, at most ceil(DEPTH/8), then S_REPORT
// loads the response. The response register frees the request side: the next
// transaction is accepted while a response waits for its consumer. No clearing
// pass is needed after reset; only cells below the count are ever read.
module deque_with_search_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dqs_req_if.sink       req_i,
  dqs_rsp_if.source     rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = $clog2(DEPTH);

  // Cell chain wiring.
  logic signed [31:0]    cell_val [DEPTH];
  logic [DEPTH-1:0]      cell_hit;
  dqs_pkg::cell_ctl_t    cell_ctl [DEPTH];

  // Control state.
  dqs_pkg::state_e       state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  dqs_pkg::status_e      status_q, status_d;
  logic                  search_q, search_d;

  // Response register.
  logic                  out_valid_q, out_valid_d;
  logic signed [31:0]    out_front_q, out_back_q;
  logic [4:0]            out_count_q;
  logic                  out_empty_q, out_found_q;
  logic [3:0]            out_pos_q;
  logic [1:0]            out_status_q;

  // Request decode.
  logic                  accept;
  logic                  is_full, is_empty_now;
  logic                  push_front_ok, push_back_ok, pop_front_ok, pop_back_ok;
  logic                  req_search;

  // FSM outputs.
  logic                  req_ready;
  logic                  scan_start;
  logic                  load_out;

  // Scanner results.
  logic                  scan_done;
  logic                  scan_found;
  logic [POS_W-1:0]      scan_pos;

  // Response assembly.
  logic signed [31:0]    back_sel;
  logic signed [31:0]    resp_front, resp_back;

  assign accept       = req_i.valid && req_ready;
  assign is_full      = (count_q == CNT_W'(DEPTH));
  assign is_empty_now = (count_q == '0);
  assign req_search   = (req_i.req_type == dqs_pkg::REQ_SEARCH);

  assign push_front_ok = accept && (req_i.req_type == dqs_pkg::REQ_PUSH_FRONT) && !is_full;
  assign push_back_ok  = accept && (req_i.req_type == dqs_pkg::REQ_PUSH_BACK) && !is_full;
  assign pop_front_ok  = accept && (req_i.req_type == dqs_pkg::REQ_POP_FRONT) && !is_empty_now;
  assign pop_back_ok   = accept && (req_i.req_type == dqs_pkg::REQ_POP_BACK) && !is_empty_now;

  // Build the cell row; cell 0 takes the request value on a front shift, the
  // last cell holds itself on a back shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_val;
    logic signed [31:0] next_val;

    if (i == 0) begin : g_first
      assign prev_val = req_i.item_value;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    assign cell_ctl[i].load      = push_back_ok && (count_q == CNT_W'(i));
    assign cell_ctl[i].shift_fwd = push_front_ok;
    assign cell_ctl[i].shift_bwd = pop_front_ok;
    assign cell_ctl[i].cmp       = accept && req_search;
    assign cell_ctl[i].active    = (CNT_W'(i) < count_q);

    dqs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl[i]),
      .item_i  (req_i.item_value),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .value_o (cell_val[i]),
      .hit_o   (cell_hit[i])
    );
  end

  dqs_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .hit_i   (cell_hit),
    .done_o  (scan_done),
    .found_o (scan_found),
    .pos_o   (scan_pos)
  );

  // Advance the count and capture the status of the accepted transaction.
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    search_d = search_q;
    if (accept) begin
      search_d = req_search;
      status_d = dqs_pkg::STATUS_DONE;
      case (req_i.req_type)
        dqs_pkg::REQ_PUSH_FRONT, dqs_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            status_d = dqs_pkg::STATUS_PUSH_FULL;
          end
        end
        dqs_pkg::REQ_POP_FRONT, dqs_pkg::REQ_POP_BACK: begin
          if (is_empty_now) begin
            status_d = dqs_pkg::STATUS_POP_EMPTY;
          end
        end
        default: begin
          status_d = dqs_pkg::STATUS_DONE;
        end
      endcase
      if (push_front_ok || push_back_ok) begin
        count_d = count_q + CNT_W'(1);
      end else if (pop_front_ok || pop_back_ok) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dqs_pkg::S_IDLE: begin
        if (accept) begin
          state_d = req_search ? dqs_pkg::S_SCAN : dqs_pkg::S_REPORT;
        end
      end
      dqs_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = dqs_pkg::S_REPORT;
        end
      end
      dqs_pkg::S_REPORT: begin
        if (load_out) begin
          state_d = dqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dqs_pkg::S_IDLE;
      end
    endcase
  end

  // FSM outputs.
  always_comb begin
    req_ready  = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      dqs_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        scan_start = req_i.valid && req_search;
      end
      dqs_pkg::S_REPORT: begin
        load_out = !out_valid_q || rsp_o.ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Pick the back element with a one-hot select on count - 1.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_q == CNT_W'(i + 1)) begin
        back_sel = back_sel | cell_val[i];
      end
    end
  end

  assign resp_front = is_empty_now ? dqs_pkg::INT_MAX : cell_val[0];
  assign resp_back  = is_empty_now ? dqs_pkg::INT_MAX : back_sel;

  // Hold the response until taken; drop valid when taken with nothing new.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqs_pkg::S_IDLE;
      count_q     <= '0;
      status_q    <= dqs_pkg::STATUS_DONE;
      search_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      status_q    <= status_d;
      search_q    <= search_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_front_q  <= resp_front;
      out_back_q   <= resp_back;
      out_count_q  <= 5'(count_q);
      out_empty_q  <= is_empty_now;
      out_found_q  <= search_q && scan_found;
      out_pos_q    <= (search_q && scan_found) ? 4'(scan_pos) : 4'd0;
      out_status_q <= status_q;
    end
  end

  assign req_i.ready          = req_ready;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.front_value    = out_front_q;
  assign rsp_o.back_value     = out_back_q;
  assign rsp_o.element_count  = out_count_q;
  assign rsp_o.is_empty       = out_empty_q;
  assign rsp_o.found          = out_found_q;
  assign rsp_o.found_position = out_pos_q;
  assign rsp_o.status         = out_status_q;

endmodule

@@ rtl/dqs_checker.sv @@
// Port-level checks of the deque responses, bound to the top level.
`timescale 1ns / 1ps
`include "deque_with_search_top_assert.svh"
module dqs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic signed [31:0] front_value_i,
  input logic signed [31:0] back_value_i,
  input logic         [4:0] element_count_i,
  input logic               is_empty_i,
  input logic               found_i,
  input logic         [3:0] found_position_i,
  input logic         [1:0] status_i
);

  // A stalled response keeps its valid and its front value.
  `DQS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(front_value_i), "response changed while stalled")

  `DQS_ASSERT_SAME(a_empty_count, clk_i, rst_ni, rsp_valid_i, is_empty_i == (element_count_i == 5'd0), "empty flag disagrees with count")

  `DQS_ASSERT_SAME(a_empty_mark, clk_i, rst_ni, rsp_valid_i && is_empty_i, (front_value_i == dqs_pkg::INT_MAX) && (back_value_i == dqs_pkg::INT_MAX), "empty deque without marker values")

  `DQS_ASSERT_SAME(a_miss_pos, clk_i, rst_ni, rsp_valid_i && !found_i, found_position_i == 4'd0, "position set without a match")

  `DQS_ASSERT_SAME(a_fail_nofind, clk_i, rst_ni, rsp_valid_i && (status_i != dqs_pkg::STATUS_DONE), !found_i, "match reported on a failed push or pop")

endmodule

bind deque_with_search_top dqs_checker u_dqs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .front_value_i    (rsp_o.front_value),
  .back_value_i     (rsp_o.back_value),
  .element_count_i  (rsp_o.element_count),
  .is_empty_i       (rsp_o.is_empty),
  .found_i          (rsp_o.found),
  .found_position_i (rsp_o.found_position),
  .status_i         (rsp_o.status)
);
